[rtl/bst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Types, codes and the control program of the binary search table.
// ----------------------------------------------------------------------------
package bst_pkg;

	localparam int VALUE_W   = 32;
	localparam int INDEX_W   = 10;
	localparam int POS_W     = 10;
	localparam int COUNT_W   = 11;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// value of the top address bit that selects the entry_count register
	localparam logic REG_ENTRY_COUNT = 1'b0;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_SEARCH = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t                  req_type;
		logic [INDEX_W-1:0]         entry_index;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
	} rsp_t;

	typedef enum logic [1:0] {
		STEP_IDLE  = 2'd0,
		STEP_START = 2'd1,
		STEP_PROBE = 2'd2,
		STEP_EMIT  = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		COND_SEARCH   = 2'd0,
		COND_EMPTY    = 2'd1,
		COND_STOP     = 2'd2,
		COND_OUT_FREE = 2'd3
	} cond_t;

	typedef struct packed {
		logic   take_in;
		logic   start;
		logic   probe;
		logic   emit;
		cond_t  cond;
		step_t  jump_to;
		step_t  seq_next;
	} ctl_word_t;

	function automatic ctl_word_t ucode(step_t s);
		ctl_word_t w;
		case (s)
			STEP_IDLE: begin
				w = '{take_in: 1'b1, start: 1'b0, probe: 1'b0, emit: 1'b0,
					cond: COND_SEARCH, jump_to: STEP_START, seq_next: STEP_IDLE};
			end
			STEP_START: begin
				w = '{take_in: 1'b0, start: 1'b1, probe: 1'b0, emit: 1'b0,
					cond: COND_EMPTY, jump_to: STEP_EMIT, seq_next: STEP_PROBE};
			end
			STEP_PROBE: begin
				w = '{take_in: 1'b0, start: 1'b0, probe: 1'b1, emit: 1'b0,
					cond: COND_STOP, jump_to: STEP_EMIT, seq_next: STEP_PROBE};
			end
			STEP_EMIT: begin
				w = '{take_in: 1'b0, start: 1'b0, probe: 1'b0, emit: 1'b1,
					cond: COND_OUT_FREE, jump_to: STEP_IDLE, seq_next: STEP_EMIT};
			end
			default: begin
				w = '{take_in: 1'b1, start: 1'b0, probe: 1'b0, emit: 1'b0,
					cond: COND_SEARCH, jump_to: STEP_START, seq_next: STEP_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/binary_search_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_search_table
// Table of signed 32-bit entries with a microcoded binary search.
// ----------------------------------------------------------------------------
// A load transfer writes one table entry and returns nothing; an index beyond
// the table is ignored. A search transfer runs a half-open binary search over
// the first entry_count entries (capped at TABLE_DEPTH) and returns one result
// after P probes, where P is at most floor(log2(entry_count)) + 1, so up to 11
// for 1024 entries; no new request is taken until that result is registered.
// One probe per cycle is set by the synchronous read of the table memory.
// The table is not cleared at reset; only loaded entries may be searched.
module binary_search_table #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bst_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bst_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bst_pkg::PADDR_W-1:0]   paddr,
	input  logic [bst_pkg::PDATA_W-1:0]   pwdata,
	output logic [bst_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bst_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int HW = AW + 1;

	step_t                      step_q, step_next;
	ctl_word_t                  ctl;
	logic                       jump;

	logic [COUNT_W-1:0]         entry_count_q;
	logic [HW-1:0]              low_q, high_q;
	logic [AW-1:0]              mid_q;
	logic signed [VALUE_W-1:0]  key_q;
	logic signed [VALUE_W-1:0]  rdata_q;
	logic                       found_q;
	logic [AW-1:0]              pos_q;

	logic signed [VALUE_W-1:0]  mem [0:TABLE_DEPTH-1];

	logic                       req_fire;
	logic                       cfg_wr;
	logic                       out_free;
	logic [HW+COUNT_W-1:0]      cnt_wide;
	logic [HW-1:0]              count_sat;
	logic [HW+INDEX_W-1:0]      idx_wide;
	logic                       idx_ok;
	logic [AW+INDEX_W-1:0]      addr_wide;
	logic                       eq_c, gt_c;
	logic [HW-1:0]              low_n, high_n, lo_c, hi_c;
	logic [HW:0]                sum_c;
	logic [AW-1:0]              mid_c;
	logic                       empty_c;
	logic [AW+POS_W-1:0]        pos_wide;

	assign ctl       = ucode(step_q);
	assign req_ready = ctl.take_in;
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid || rsp_ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ENTRY_COUNT);
	assign prdata = (paddr[PADDR_W-1] == REG_ENTRY_COUNT) ?
		{{(PDATA_W-COUNT_W){1'b0}}, entry_count_q} : '0;

	assign cnt_wide  = {{HW{1'b0}}, entry_count_q};
	assign count_sat = (cnt_wide > (HW+COUNT_W)'(TABLE_DEPTH)) ?
		HW'(TABLE_DEPTH) : cnt_wide[HW-1:0];

	assign idx_wide  = {{HW{1'b0}}, req.entry_index};
	assign idx_ok    = idx_wide < (HW+INDEX_W)'(TABLE_DEPTH);
	assign addr_wide = {{AW{1'b0}}, req.entry_index};

	assign eq_c   = key_q == rdata_q;
	assign gt_c   = key_q > rdata_q;
	assign low_n  = gt_c ? ({1'b0, mid_q} + HW'(1)) : low_q;
	assign high_n = (!gt_c && !eq_c) ? {1'b0, mid_q} : high_q;

	assign lo_c    = ctl.probe ? low_n : low_q;
	assign hi_c    = ctl.probe ? high_n : high_q;
	assign sum_c   = {1'b0, lo_c} + {1'b0, hi_c};
	assign mid_c   = sum_c[AW:1];
	assign empty_c = lo_c >= hi_c;

	assign pos_wide = {{POS_W{1'b0}}, pos_q};

	always_comb begin
		case (ctl.cond)
			COND_SEARCH:   jump = req_fire && (req.req_type == REQ_SEARCH);
			COND_EMPTY:    jump = empty_c;
			COND_STOP:     jump = eq_c || empty_c;
			COND_OUT_FREE: jump = out_free;
			default:       jump = 1'b0;
		endcase
		step_next = jump ? ctl.jump_to : ctl.seq_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= STEP_IDLE;
			entry_count_q <= '0;
			rsp_valid     <= 1'b0;
		end else begin
			step_q <= step_next;
			if (cfg_wr) begin
				entry_count_q <= pwdata[COUNT_W-1:0];
			end
			if (ctl.emit && out_free) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && (req.req_type == REQ_SEARCH)) begin
			low_q   <= '0;
			high_q  <= count_sat;
			key_q   <= req.value;
			found_q <= 1'b0;
		end
		if (ctl.start || ctl.probe) begin
			mid_q <= mid_c;
		end
		if (ctl.probe) begin
			low_q  <= low_n;
			high_q <= high_n;
			if (eq_c) begin
				found_q <= 1'b1;
				pos_q   <= mid_q;
			end
		end
		if (ctl.emit && out_free) begin
			rsp.found    <= found_q;
			rsp.position <= found_q ? pos_wide[POS_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && (req.req_type == REQ_LOAD) && idx_ok) begin
			mem[addr_wide[AW-1:0]] <= req.value;
		end
		rdata_q <= mem[mid_c];
	end

endmodule
